// ----- design/btt_pkg.sv -----
package btt_pkg;

  localparam int MAX_BUCKETS = 4096;
  localparam int WAYS        = 4;

  localparam int IDX_W  = $clog2(MAX_BUCKETS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int HALF_W = 32;
  localparam int PROD_W = HALF_W + CNT_W;
  localparam int TAG_W  = 16;
  localparam int AGE_W  = 8;
  localparam int SCORE_W = 16;
  localparam int SUM_W  = SCORE_W + 1;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_AGE   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic [AGE_W-1:0]          age;
    logic signed [SCORE_W-1:0] action;
    logic signed [SCORE_W-1:0] eval;
  } slot_t;

  localparam int SLOT_W   = $bits(slot_t);
  localparam int BUCKET_W = WAYS * SLOT_W;

  typedef slot_t [WAYS-1:0] bucket_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        hash;
    logic [1:0]         way;
    logic signed [15:0] action;
    logic signed [31:0] eval;
  } btt_in_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         chosen_way;
    logic signed [15:0] found_action;
    logic signed [15:0] found_eval;
    logic [7:0]         found_age;
    logic               written;
  } btt_out_t;

  function automatic logic signed [SUM_W-1:0] slot_sum(input slot_t s);
    return SUM_W'(s.action) + SUM_W'(s.eval);
  endfunction

endpackage

// ----- design/btt_ram.sv -----
module btt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/btt_mul.sv -----
module btt_mul import btt_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [HALF_W-1:0] a,
  input  logic [CNT_W-1:0]  b,
  input  logic [CNT_W-1:0]  addend,
  output logic [PROD_W-1:0] p
);

  // shared 32 x 13 multiply-add, used once per hash half
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b) + PROD_W'(addend);
    end
  end

endmodule

// ----- design/btt_resolve.sv -----
module btt_resolve import btt_pkg::*; (
  input  bucket_t           bucket,
  input  btt_in_t           item,
  input  logic [AGE_W-1:0]  cur_age,
  output btt_out_t          res,
  output bucket_t           new_bucket
);

  always_comb begin
    logic [TAG_W-1:0]   tag;
    logic               hit;
    logic [WAY_W-1:0]   hit_way;
    logic [WAY_W-1:0]   vic;
    logic [WAY_W-1:0]   sw;
    slot_t              old_s;
    slot_t              fresh;
    slot_t              pick;
    logic signed [32:0] old_sum;
    logic signed [32:0] new_sum;
    logic               wr;

    tag     = item.hash[TAG_W-1:0];
    hit     = 1'b0;
    hit_way = '0;
    // walk downwards so the lowest matching way wins
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (bucket[i].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
    end

    vic = '0;
    for (int i = 1; i < WAYS; i++) begin
      if ((bucket[i].age == bucket[vic].age && slot_sum(bucket[i]) < slot_sum(bucket[vic]))
          || bucket[i].age < bucket[vic].age) begin
        vic = WAY_W'(i);
      end
    end

    sw      = item.way[WAY_W-1:0];
    old_s   = bucket[sw];
    old_sum = 33'(slot_sum(old_s));
    new_sum = 33'(item.action) + 33'(item.eval);
    wr      = (old_s.tag != tag) || (old_s.age != cur_age) || (old_sum < new_sum);

    fresh.tag    = tag;
    fresh.age    = cur_age;
    fresh.action = item.action;
    if (item.eval > 32'sh0000_7FFF) begin
      fresh.eval = 16'sh7FFF;
    end else if (item.eval < -32'sh0000_8000) begin
      fresh.eval = 16'sh8000;
    end else begin
      fresh.eval = item.eval[SCORE_W-1:0];
    end

    new_bucket = bucket;
    new_bucket[sw] = fresh;

    if (item.operation == OP_STORE) begin
      pick           = wr ? fresh : old_s;
      res.hit        = 1'b0;
      res.chosen_way = 2'(sw);
      res.written    = wr;
    end else begin
      pick           = hit ? bucket[hit_way] : bucket[vic];
      res.hit        = hit;
      res.chosen_way = hit ? 2'(hit_way) : 2'(vic);
      res.written    = 1'b0;
    end
    res.found_action = pick.action;
    res.found_eval   = pick.eval;
    res.found_age    = pick.age;
  end

endmodule

// ----- design/bucketed_transposition_table_top.sv -----
// channel  direction  handshake              word
// req      in         req_valid / req_ready  btt_in_t  (operation, hash, way, action, eval)
// rsp      out        rsp_valid / rsp_ready  btt_out_t (hit, chosen_way, found_*, written)
// cfg      in         cfg_we                 cfg_data  (bucket_count)
//
// Probe and store: the word goes through S_LO, S_HI, S_ADDR and S_EVAL; hash * bucket_count is
// done in two passes of one 32x13 multiplier, then one bucket read and an optional write-back.
// Advance age: through S_ZERO. Clear: all 4096 buckets swept, one bucket zeroed per cycle, then S_ZERO.
// After reset a sweep zeroes all 4096 buckets of the bucket memory; req_ready stays low meanwhile.
// A result waits in the rsp register; the block holds the next result until it is taken.
module bucketed_transposition_table_top import btt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  btt_in_t          req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output btt_out_t         rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_LO, S_HI, S_ADDR, S_EVAL, S_CLEAR, S_ZERO
  } state_t;

  state_t            state;
  btt_in_t           item;
  logic [AGE_W-1:0]  cur_age;
  logic [CNT_W-1:0]  bucket_count;
  logic [IDX_W-1:0]  sweep;

  logic              out_free;
  logic              rsp_load;
  logic              sweeping;
  logic [CNT_W-1:0]  cnt_clamped;
  logic              mul_en;
  logic [HALF_W-1:0] mul_a;
  logic [CNT_W-1:0]  mul_addend;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  mid;
  logic [IDX_W-1:0]  bucket_idx;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [BUCKET_W-1:0] ram_wdata;
  logic [BUCKET_W-1:0] ram_rdata;
  btt_out_t          res;
  bucket_t           new_bucket;

  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = ((state == S_EVAL) || (state == S_ZERO)) && out_free;
  assign sweeping  = (state == S_INIT) || (state == S_CLEAR);
  assign req_ready = (state == S_IDLE);

  assign cnt_clamped = (bucket_count > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : bucket_count;

  // low half first; its carry bits feed the high half
  assign mul_en     = (state == S_LO) || (state == S_HI);
  assign mul_a      = (state == S_LO) ? item.hash[HALF_W-1:0] : item.hash[63:HALF_W];
  assign mul_addend = (state == S_HI) ? prod[PROD_W-1:HALF_W] : '0;

  btt_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (cnt_clamped),
    .addend (mul_addend),
    .p      (prod)
  );

  assign mid        = prod[PROD_W-1:HALF_W];
  assign bucket_idx = (mid >= CNT_W'(MAX_BUCKETS)) ? IDX_W'(MAX_BUCKETS - 1) : mid[IDX_W-1:0];

  assign ram_we    = sweeping || (state == S_EVAL && out_free && res.written);
  assign ram_waddr = sweeping ? sweep : bucket_idx;
  assign ram_wdata = sweeping ? '0 : BUCKET_W'(new_bucket);

  btt_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_ADDR),
    .raddr (bucket_idx),
    .rdata (ram_rdata)
  );

  btt_resolve u_resolve (
    .bucket     (bucket_t'(ram_rdata)),
    .item       (item),
    .cur_age    (cur_age),
    .res        (res),
    .new_bucket (new_bucket)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      rsp_valid    <= 1'b0;
      cur_age      <= '0;
      bucket_count <= CNT_W'(MAX_BUCKETS);
      sweep        <= '0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state) inside
        S_INIT, S_CLEAR: begin
          if (sweep == IDX_W'(MAX_BUCKETS - 1)) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_ZERO;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            unique case (req.operation) inside
              OP_PROBE, OP_STORE: state <= S_LO;
              OP_AGE: begin
                cur_age <= cur_age + 1'b1;
                state   <= S_ZERO;
              end
              OP_CLEAR: state <= S_CLEAR;
            endcase
          end
        end
        S_LO:   state <= S_HI;
        S_HI:   state <= S_ADDR;
        S_ADDR: state <= S_EVAL;
        S_EVAL: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            rsp   <= '0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_age_step: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.operation == OP_AGE) |=> cur_age == $past(cur_age) + 8'd1)
    else $error("age did not advance by one");

  a_sweep_zero: assert property (@(posedge clk) disable iff (rst)
    (ram_we && sweeping) |-> ram_wdata == '0)
    else $error("sweep wrote non-zero bucket");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !ram_we)
    else $error("bucket write while idle");

  a_store_no_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && item.operation == OP_STORE) |-> !res.hit)
    else $error("store reported a hit");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import btt_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  btt_in_t          req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  btt_out_t         rsp;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  bucketed_transposition_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the table
  slot_t            tt_shadow [MAX_BUCKETS][WAYS];
  logic [AGE_W-1:0] tt_age = '0;
  logic [CNT_W-1:0] tt_buckets = CNT_W'(MAX_BUCKETS);

  btt_in_t  tt_pending [$];
  btt_out_t tt_expected [$];
  logic [63:0] pos_pool [8];

  int fail_count = 0;
  bit no_idle = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void tt_wipe();
    foreach (tt_shadow[i, j]) tt_shadow[i][j] = '0;
  endfunction

  function automatic int score_sum(slot_t s);
    return int'(s.action) + int'(s.eval);
  endfunction

  function automatic btt_out_t tt_predict(btt_in_t w);
    btt_out_t         r;
    logic [76:0]      prod;
    logic [CNT_W-1:0] c;
    int               b;
    int               v;
    bit               found;
    bit               wr;
    logic [TAG_W-1:0] t;
    slot_t            s;
    r = '0;
    found = 1'b0;
    c = (tt_buckets > MAX_BUCKETS) ? CNT_W'(MAX_BUCKETS) : tt_buckets;
    prod = 77'(w.hash) * 77'(c);
    b = int'(prod[76:64]);
    if (b >= MAX_BUCKETS) b = MAX_BUCKETS - 1;
    t = w.hash[TAG_W-1:0];
    case (w.operation)
      OP_PROBE: begin
        for (int i = 0; i < WAYS; i++) begin
          if (!found && tt_shadow[b][i].tag == t) begin
            found = 1'b1;
            v = i;
          end
        end
        if (!found) begin
          v = 0;
          for (int i = 1; i < WAYS; i++) begin
            if ((tt_shadow[b][i].age == tt_shadow[b][v].age &&
                 score_sum(tt_shadow[b][i]) < score_sum(tt_shadow[b][v])) ||
                tt_shadow[b][i].age < tt_shadow[b][v].age)
              v = i;
          end
        end
        s = tt_shadow[b][v];
        r.hit = found;
        r.chosen_way = v[1:0];
        r.found_action = s.action;
        r.found_eval = s.eval;
        r.found_age = s.age;
      end
      OP_STORE: begin
        s = tt_shadow[b][w.way];
        // compare against the unsaturated eval
        wr = s.tag != t || s.age != tt_age ||
             longint'(score_sum(s)) < longint'(w.action) + longint'(w.eval);
        if (wr) begin
          s.tag = t;
          s.age = tt_age;
          s.action = w.action;
          if (w.eval > 32767) s.eval = 16'sh7fff;
          else if (w.eval < -32768) s.eval = 16'sh8000;
          else s.eval = w.eval[15:0];
          tt_shadow[b][w.way] = s;
        end
        r.chosen_way = w.way;
        r.found_action = s.action;
        r.found_eval = s.eval;
        r.found_age = s.age;
        r.written = wr;
      end
      OP_AGE: begin
        tt_age = tt_age + 1'b1;
      end
      OP_CLEAR: begin
        tt_wipe();
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) tt_expected.push_back(tt_predict(req));
      if (!req_valid || req_ready) begin
        if (tt_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
          req_valid <= 1'b1;
          req <= tt_pending.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    btt_out_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (tt_expected.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, rsp);
          fail_count++;
        end else begin
          want = tt_expected.pop_front();
          check_field("hit", want.hit, rsp.hit);
          check_field("chosen_way", want.chosen_way, rsp.chosen_way);
          check_field("found_action", want.found_action, rsp.found_action);
          check_field("found_eval", want.found_eval, rsp.found_eval);
          check_field("found_age", want.found_age, rsp.found_age);
          check_field("written", want.written, rsp.written);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= 400;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= no_idle || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  task automatic queue_op(logic [1:0] op, logic [63:0] h, logic [1:0] way,
                          logic signed [15:0] act, logic signed [31:0] ev);
    btt_in_t w;
    w.operation = op;
    w.hash = h;
    w.way = way;
    w.action = act;
    w.eval = ev;
    tt_pending.push_back(w);
  endtask

  function automatic logic signed [15:0] rand_action();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_eval();
    case ($urandom_range(0, 3))
      0: return 32'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd32767;
          3: return 32'sd32768;
          4: return -32'sd32768;
          default: return -32'sd32769;
        endcase
      end
      default: return 32'($urandom_range(0, 80000) - 40000);
    endcase
  endfunction

  // a handful of positions, many sharing a bucket and some a tag
  task automatic refresh_pool();
    logic [31:0] hi;
    hi = $urandom;
    for (int i = 0; i < 8; i++)
      pos_pool[i] = {($urandom_range(0, 1) ? hi : 32'($urandom)), 32'($urandom)};
    pos_pool[7][15:0] = pos_pool[6][15:0];
  endtask

  task automatic queue_burst(int n);
    btt_in_t w;
    int      r;
    refresh_pool();
    for (int k = 0; k < n; k++) begin
      w.hash = pos_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 99) < 10) w.hash = {32'($urandom), 32'($urandom)};
      w.way = 2'($urandom_range(0, 3));
      w.action = rand_action();
      w.eval = rand_eval();
      r = $urandom_range(0, 99);
      w.operation = r < 47 ? OP_PROBE : r < 93 ? OP_STORE : r < 99 ? OP_AGE : OP_CLEAR;
      tt_pending.push_back(w);
      // probe followed half the time by a store to the same position
      if (w.operation == OP_PROBE && $urandom_range(0, 1)) begin
        w.operation = OP_STORE;
        w.way = 2'($urandom_range(0, 3));
        w.action = rand_action();
        w.eval = rand_eval();
        tt_pending.push_back(w);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tt_pending.size() != 0 || req_valid || tt_expected.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_bucket_count(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tt_buckets = v;
  endtask

  initial begin
    logic [63:0] h_top;
    logic [63:0] h_one;
    h_top = 64'hFFFF_FFFF_FFFF_FFFF;
    h_one = 64'hFFFF_FFFF_FFFF_0001;
    tt_wipe();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    load_bucket_count(CNT_W'(MAX_BUCKETS));

    queue_op(OP_PROBE, 64'h0, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_PROBE, h_top, 2'd3, 16'sd0, 32'sd0);
    queue_op(OP_STORE, h_top, 2'd3, 16'sh7fff, 32'sh7fff_ffff);
    queue_op(OP_STORE, h_top, 2'd3, 16'sh7fff, 32'sh7fff_ffff);
    queue_op(OP_STORE, h_top, 2'd3, 16'sd0, 32'sd0);
    queue_op(OP_STORE, h_top, 2'd2, 16'sh8000, 32'sh8000_0000);
    queue_op(OP_PROBE, h_top, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_PROBE, h_one, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_AGE, h_top, 2'd3, 16'sh7fff, 32'sh7fff_ffff);
    queue_op(OP_STORE, h_one, 2'd0, 16'sd5, -32'sd5);
    queue_op(OP_STORE, h_one, 2'd0, 16'sd1, -32'sd1);
    queue_op(OP_PROBE, h_one, 2'd1, 16'sd0, 32'sd0);
    queue_op(OP_PROBE, 64'hFFFF_FFFF_FFFF_0002, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_PROBE, 64'h8000_0000_0000_0000, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_STORE, 64'h8000_0000_0000_0000, 2'd1, -16'sd1, 32'sd32768);
    queue_op(OP_CLEAR, h_one, 2'd1, 16'sd1, 32'sd1);
    queue_op(OP_PROBE, h_top, 2'd0, 16'sd0, 32'sd0);
    queue_op(OP_PROBE, h_one, 2'd0, 16'sd0, 32'sd0);
    wait_idle();

    // zero buckets: everything lands in bucket zero
    load_bucket_count('0);
    queue_burst(100);
    wait_idle();

    // long hold-off on the result side while requests keep coming
    load_bucket_count(CNT_W'(1));
    queue_burst(100);
    hold_reqs++;
    wait_idle();

    // above the table size: clamped
    load_bucket_count('1);
    queue_burst(150);
    wait_idle();

    // walk the age counter through its wrap
    for (int i = 0; i < 260; i++) begin
      queue_op(OP_AGE, {32'($urandom), 32'($urandom)}, 2'($urandom_range(0, 3)),
               rand_action(), rand_eval());
      if (i % 20 == 0) queue_burst(2);
    end
    wait_idle();

    no_idle = 1'b1;
    load_bucket_count(CNT_W'(3));
    queue_burst(150);
    wait_idle();
    no_idle = 1'b0;

    load_bucket_count(CNT_W'(MAX_BUCKETS));
    queue_burst(150);
    wait_idle();

    load_bucket_count(CNT_W'($urandom_range(2, MAX_BUCKETS - 1)));
    queue_burst(110);
    wait_idle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
